[hdl/iub_pkg.sv]
package iub_pkg;

	localparam int KIND_W = 2;
	localparam logic [KIND_W-1:0] KIND_DATA  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLOSE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PULL  = 2'd2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_ADDRESS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_ADDRESS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_PORT      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PORT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IDENT          = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SERVICE_TYPE   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HOP_LIMIT      = 3'd6;

	localparam logic [7:0]  IP_VER_IHL   = 8'h45;
	localparam logic [7:0]  PROTO_UDP    = 8'd17;
	localparam logic [15:0] IP_HDR_LEN   = 16'd20;
	localparam logic [15:0] UDP_HDR_LEN  = 16'd8;
	localparam logic [15:0] HDRS_LEN     = 16'd28;
	localparam logic [15:0] CHECK_ALL_1  = 16'hFFFF;

	localparam logic [15:0] RST_SOURCE_PORT  = 16'd65001;
	localparam logic [7:0]  RST_SERVICE_TYPE = 8'd1;
	localparam logic [7:0]  RST_HOP_LIMIT    = 8'h40;

	typedef logic [15:0] csum_t;

	// Ones'-complement add of one 16-bit word with end-around carry.
	function automatic csum_t csum_add(input csum_t acc, input csum_t word);
		logic [16:0] s;
		s = {1'b0, acc} + {1'b0, word};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

[hdl/ipv4_udp_frame_builder_top.sv]
// IPv4/UDP frame builder. Payload words (kind 0) are stored in an internal byte memory while
// a running ones'-complement sum is kept. Once a close word (kind 1) is accepted, a single
// 16-bit end-around-carry adder folds in the pseudo-header and UDP header words and then the
// IPv4 header words. Each pull word (kind 2) returns one frame byte, or an empty result flagged
// by none_ready while no frame is closed; header bytes are registered straight into the output,
// payload bytes first pass through the registered memory read data. The block takes a
// new word only once the previous one is finished and the output register is free or being
// emptied. The payload memory needs no clearing after reset.
module ipv4_udp_frame_builder_top #(
	parameter int MAX_PAYLOAD = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [iub_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [iub_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [iub_pkg::KIND_W-1:0]     kind,
	input  logic [7:0]                     payload_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [7:0]                     frame_byte,
	output logic                           last_byte,
	output logic                           none_ready
);
	import iub_pkg::*;

	localparam int CW = $clog2(MAX_PAYLOAD + 1);
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
	localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_PAYLOAD);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_CLOSE = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;

	localparam logic [4:0] STEP_UDP_LAST = 5'd8;
	localparam logic [4:0] STEP_HDR_LAST = 5'd16;

	logic [31:0] source_address_q, dest_address_q;
	logic [15:0] dest_port_q, source_port_q, ident_q;
	logic [7:0]  service_type_q, hop_limit_q;

	logic [7:0]    mem [MAX_PAYLOAD];
	logic [7:0]    rdata_q;
	logic [CW-1:0] count_q;
	csum_t         sum_q;
	logic          odd_q;
	logic          frame_ready_q;
	logic [15:0]   pos_q;
	csum_t         udp_check_q, header_check_q;
	logic [1:0]    state_q;
	logic [4:0]    step_q;
	logic          pend_last_q;

	logic          out_valid_q, out_last_q, out_none_q;
	logic [7:0]    out_byte_q;

	logic          accept, take_data, take_close, take_pull, rd_en, is_last;
	logic [15:0]   total_len, udp_len, rd_off;
	logic [223:0]  hdr_bytes;
	logic [4:0]    hdr_idx;
	logic [7:0]    hdr_byte;
	csum_t         data_word, step_word, sum_next, udp_fixed;

	assign in_ready   = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept     = in_valid && in_ready;
	assign take_data  = accept && (kind == KIND_DATA) && !frame_ready_q && (count_q < COUNT_MAX);
	assign take_close = accept && (kind == KIND_CLOSE) && !frame_ready_q;
	assign take_pull  = accept && (kind == KIND_PULL);

	assign total_len = HDRS_LEN + 16'(count_q);
	assign udp_len   = UDP_HDR_LEN + 16'(count_q);
	assign is_last   = (pos_q + 16'd1) == total_len;
	assign rd_off    = pos_q - HDRS_LEN;
	assign rd_en     = take_pull && frame_ready_q && (pos_q >= HDRS_LEN);

	assign hdr_bytes = {IP_VER_IHL, service_type_q, total_len, ident_q, 16'h0000,
		hop_limit_q, PROTO_UDP, header_check_q, source_address_q, dest_address_q,
		source_port_q, dest_port_q, udp_len, udp_check_q};
	assign hdr_idx   = 5'd27 - pos_q[4:0];
	assign hdr_byte  = hdr_bytes[hdr_idx*8 +: 8];

	assign data_word = odd_q ? {8'h00, payload_byte} : {payload_byte, 8'h00};

	always_comb begin
		case (step_q)
			5'd0:    step_word = source_address_q[31:16];
			5'd1:    step_word = source_address_q[15:0];
			5'd2:    step_word = dest_address_q[31:16];
			5'd3:    step_word = dest_address_q[15:0];
			5'd4:    step_word = {8'h00, PROTO_UDP};
			5'd5:    step_word = udp_len;
			5'd6:    step_word = source_port_q;
			5'd7:    step_word = dest_port_q;
			5'd8:    step_word = udp_len;
			5'd9:    step_word = {IP_VER_IHL, service_type_q};
			5'd10:   step_word = total_len;
			5'd11:   step_word = ident_q;
			5'd12:   step_word = {hop_limit_q, PROTO_UDP};
			5'd13:   step_word = source_address_q[31:16];
			5'd14:   step_word = source_address_q[15:0];
			5'd15:   step_word = dest_address_q[31:16];
			5'd16:   step_word = dest_address_q[15:0];
			default: step_word = '0;
		endcase
	end

	// The one shared adder serves both payload accumulation and the close sequence.
	assign sum_next  = csum_add(sum_q, (state_q == ST_CLOSE) ? step_word : data_word);
	assign udp_fixed = (~sum_next == 16'h0000) ? CHECK_ALL_1 : ~sum_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_address_q <= '0;
			dest_address_q   <= '0;
			dest_port_q      <= '0;
			source_port_q    <= RST_SOURCE_PORT;
			ident_q          <= '0;
			service_type_q   <= RST_SERVICE_TYPE;
			hop_limit_q      <= RST_HOP_LIMIT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE_ADDRESS: source_address_q <= cfg_data;
				REG_DEST_ADDRESS:   dest_address_q   <= cfg_data;
				REG_DEST_PORT:      dest_port_q      <= cfg_data[15:0];
				REG_SOURCE_PORT:    source_port_q    <= cfg_data[15:0];
				REG_IDENT:          ident_q          <= cfg_data[15:0];
				REG_SERVICE_TYPE:   service_type_q   <= cfg_data[7:0];
				REG_HOP_LIMIT:      hop_limit_q      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take_data)
			mem[count_q[AW-1:0]] <= payload_byte;
		if (rd_en)
			rdata_q <= mem[rd_off[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q        <= '0;
			sum_q          <= '0;
			odd_q          <= 1'b0;
			frame_ready_q  <= 1'b0;
			pos_q          <= '0;
			udp_check_q    <= '0;
			header_check_q <= '0;
			state_q        <= ST_IDLE;
			step_q         <= '0;
			pend_last_q    <= 1'b0;
			out_valid_q    <= 1'b0;
			out_last_q     <= 1'b0;
			out_none_q     <= 1'b0;
			out_byte_q     <= '0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (take_data) begin
						count_q <= count_q + CW'(1);
						sum_q   <= sum_next;
						odd_q   <= !odd_q;
					end
					if (take_close) begin
						state_q <= ST_CLOSE;
						step_q  <= '0;
					end
					if (take_pull) begin
						if (!frame_ready_q) begin
							out_valid_q <= 1'b1;
							out_byte_q  <= '0;
							out_last_q  <= 1'b0;
							out_none_q  <= 1'b1;
						end else begin
							if (pos_q >= HDRS_LEN) begin
								state_q     <= ST_READ;
								pend_last_q <= is_last;
							end else begin
								out_valid_q <= 1'b1;
								out_byte_q  <= hdr_byte;
								out_last_q  <= is_last;
								out_none_q  <= 1'b0;
							end
							if (is_last) begin
								count_q       <= '0;
								sum_q         <= '0;
								odd_q         <= 1'b0;
								frame_ready_q <= 1'b0;
								pos_q         <= '0;
							end else begin
								pos_q <= pos_q + 16'd1;
							end
						end
					end
				end
				ST_CLOSE: begin
					sum_q  <= sum_next;
					step_q <= step_q + 5'd1;
					if (step_q == STEP_UDP_LAST) begin
						udp_check_q <= udp_fixed;
						sum_q       <= '0;
					end
					if (step_q == STEP_HDR_LAST) begin
						header_check_q <= ~sum_next;
						sum_q          <= '0;
						frame_ready_q  <= 1'b1;
						pos_q          <= '0;
						state_q        <= ST_IDLE;
					end
				end
				ST_READ: begin
					out_valid_q <= 1'b1;
					out_byte_q  <= rdata_q;
					out_last_q  <= pend_last_q;
					out_none_q  <= 1'b0;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign frame_byte = out_byte_q;
	assign last_byte  = out_last_q;
	assign none_ready = out_none_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_MAX)
		else $error("payload count beyond capacity");

	a_idle_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!frame_ready_q |-> pos_q == 16'd0)
		else $error("read position moved without a closed frame");

	a_close_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLOSE) |-> !frame_ready_q && !in_ready)
		else $error("checksum sequence running over a pending frame");

	a_none_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && none_ready) |-> (frame_byte == 8'h00) && !last_byte)
		else $error("empty pull result carries data");

	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		frame_ready_q |-> pos_q < total_len)
		else $error("read position past end of frame");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

module testbench;
	import iub_pkg::*;

	localparam int PAYLOAD_CAP = 1024;
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int LONG_HOLD = 300;
	localparam int RANDOM_WORDS = 100;
	localparam int LIMIT_CYCLES = 1000000;

	typedef struct packed {
		logic [7:0] octet;
		logic       last;
		logic       none;
	} frame_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic [KIND_W-1:0]     kind;
	logic [7:0]            payload_byte;
	logic                  out_valid;
	logic                  out_ready;
	logic [7:0]            frame_byte;
	logic                  last_byte;
	logic                  none_ready;

	ipv4_udp_frame_builder_top #(
		.MAX_PAYLOAD(PAYLOAD_CAP)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.payload_byte(payload_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.frame_byte(frame_byte),
		.last_byte(last_byte),
		.none_ready(none_ready)
	);

	// Register copies and frame state of the builder as this bench tracks it.
	logic [31:0] cfg_src_addr;
	logic [31:0] cfg_dst_addr;
	logic [15:0] cfg_dst_port;
	logic [15:0] cfg_src_port;
	logic [15:0] cfg_ident;
	logic [7:0]  cfg_tos;
	logic [7:0]  cfg_ttl;

	logic [7:0]  pl_bytes [PAYLOAD_CAP];
	int unsigned pl_count;
	int unsigned pl_sum;
	bit          odd_byte;
	bit          frame_closed;
	int unsigned rd_pos;
	logic [15:0] udp_ck;
	logic [15:0] hdr_ck;

	frame_word_t expected_frame_bytes[$];
	frame_word_t next_word;
	int unsigned words_used;
	int unsigned errors;
	int unsigned burst_left;
	bit          rx_hold_req;
	int unsigned cycle_count;

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int unsigned oc_add(input int unsigned acc, input logic [15:0] w);
		acc += {16'd0, w};
		acc = (acc & 32'hFFFF) + (acc >> 16);
		acc = (acc & 32'hFFFF) + (acc >> 16);
		return acc;
	endfunction

	function automatic int unsigned oc_add32(input int unsigned acc, input logic [31:0] a);
		return oc_add(oc_add(acc, a[31:16]), a[15:0]);
	endfunction

	function automatic logic [15:0] udp_sum_complement(input int unsigned sum,
			input int unsigned count);
		int unsigned s;
		int unsigned udp_len;
		udp_len = UDP_HDR_LEN + count;
		s = sum & 32'h1FFFF;
		s = (s & 32'hFFFF) + (s >> 16);
		s = oc_add32(s, cfg_src_addr);
		s = oc_add32(s, cfg_dst_addr);
		s = oc_add(s, {8'h00, PROTO_UDP});
		s = oc_add(s, 16'(udp_len));
		s = oc_add(s, cfg_src_port);
		s = oc_add(s, cfg_dst_port);
		s = oc_add(s, 16'(udp_len));
		return ~s[15:0];
	endfunction

	function automatic logic [15:0] hdr_sum_complement(input int unsigned count);
		int unsigned s;
		s = oc_add(0, {IP_VER_IHL, cfg_tos});
		s = oc_add(s, 16'(HDRS_LEN + count));
		s = oc_add(s, cfg_ident);
		s = oc_add(s, {cfg_ttl, PROTO_UDP});
		s = oc_add32(s, cfg_src_addr);
		s = oc_add32(s, cfg_dst_addr);
		return ~s[15:0];
	endfunction

	function automatic logic [7:0] frame_octet(input int unsigned pos);
		logic [15:0] total;
		logic [15:0] udp_len;
		total = 16'(HDRS_LEN + pl_count);
		udp_len = 16'(UDP_HDR_LEN + pl_count);
		if (pos >= HDRS_LEN) begin
			return (pos - HDRS_LEN < PAYLOAD_CAP) ? pl_bytes[pos - HDRS_LEN] : 8'h00;
		end
		case (pos)
			0: return IP_VER_IHL;
			1: return cfg_tos;
			2: return total[15:8];
			3: return total[7:0];
			4: return cfg_ident[15:8];
			5: return cfg_ident[7:0];
			6, 7: return 8'h00;
			8: return cfg_ttl;
			9: return PROTO_UDP;
			10: return hdr_ck[15:8];
			11: return hdr_ck[7:0];
			12, 13, 14, 15: return cfg_src_addr[8 * (15 - pos) +: 8];
			16, 17, 18, 19: return cfg_dst_addr[8 * (19 - pos) +: 8];
			20: return cfg_src_port[15:8];
			21: return cfg_src_port[7:0];
			22: return cfg_dst_port[15:8];
			23: return cfg_dst_port[7:0];
			24: return udp_len[15:8];
			25: return udp_len[7:0];
			26: return udp_ck[15:8];
			default: return udp_ck[7:0];
		endcase
	endfunction

	function automatic void clear_frame_state();
		pl_count = 0;
		pl_sum = 0;
		odd_byte = 1'b0;
		frame_closed = 1'b0;
		rd_pos = 0;
	endfunction

	function automatic void advance_frame_state(input logic [KIND_W-1:0] k,
			input logic [7:0] d);
		frame_word_t w;
		case (k)
			KIND_DATA: begin
				if (!frame_closed && pl_count < PAYLOAD_CAP) begin
					pl_bytes[pl_count] = d;
					pl_count++;
					pl_sum = oc_add(pl_sum, odd_byte ? {8'h00, d} : {d, 8'h00});
					odd_byte = !odd_byte;
					words_used++;
				end
			end
			KIND_CLOSE: begin
				if (!frame_closed) begin
					udp_ck = udp_sum_complement(pl_sum, pl_count);
					if (udp_ck == 16'h0000) begin
						udp_ck = CHECK_ALL_1;
					end
					hdr_ck = hdr_sum_complement(pl_count);
					frame_closed = 1'b1;
					rd_pos = 0;
					words_used++;
				end
			end
			KIND_PULL: begin
				words_used++;
				if (!frame_closed) begin
					w = '{octet: 8'h00, last: 1'b0, none: 1'b1};
				end else begin
					w.octet = frame_octet(rd_pos);
					w.last = (rd_pos + 1 >= HDRS_LEN + pl_count);
					w.none = 1'b0;
					if (w.last) begin
						clear_frame_state();
					end else begin
						rd_pos++;
					end
				end
				expected_frame_bytes.push_back(w);
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_field(input int bits);
		logic [31:0] mask;
		mask = (bits == 32) ? 32'hFFFF_FFFF : (32'd1 << bits) - 1;
		case ($urandom_range(0, 3))
			0: return 32'd0;
			1: return mask;
			default: return $urandom & mask;
		endcase
	endfunction

	always @(negedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_ready === 1'b1) begin
			if (expected_frame_bytes.size() == 0) begin
				$error("unexpected word: frame_byte %h last_byte %b none_ready %b",
					frame_byte, last_byte, none_ready);
				errors++;
			end else begin
				next_word = expected_frame_bytes.pop_front();
				if (frame_byte !== next_word.octet) begin
					$error("frame_byte: expected %h, got %h", next_word.octet, frame_byte);
					errors++;
				end
				if (last_byte !== next_word.last) begin
					$error("last_byte: expected %b, got %b", next_word.last, last_byte);
					errors++;
				end
				if (none_ready !== next_word.none) begin
					$error("none_ready: expected %b, got %b", next_word.none, none_ready);
					errors++;
				end
			end
		end
	end

	// The receiver stalls on a rotating pattern that is redrawn now and then; on
	// request it holds off for a long stretch so that the builder backs up.
	initial begin : rx_stall
		logic [15:0] rx_pattern;
		int unsigned rx_left;
		out_ready <= 1'b0;
		rx_pattern = 16'hFFFF;
		rx_left = 0;
		forever begin
			@(posedge clk);
			if (rx_hold_req) begin
				rx_hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				if (rx_left == 0) begin
					rx_left = $urandom_range(32, 256);
					case ($urandom_range(0, 3))
						0: rx_pattern = 16'hFFFF;
						1: rx_pattern = 16'($urandom);
						2: rx_pattern = 16'($urandom | $urandom);
						default: rx_pattern = 16'(($urandom & $urandom) | 32'h0001);
					endcase
				end
				out_ready <= rx_pattern[0];
				rx_pattern = {rx_pattern[0], rx_pattern[15:1]};
				rx_left--;
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Verification failed");
		$finish;
	end

	task automatic send_word(input logic [KIND_W-1:0] k, input logic [7:0] d);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		kind <= k;
		payload_byte <= d;
		@(negedge clk);
		while (in_ready !== 1'b1) @(negedge clk);
		@(posedge clk);
		advance_frame_state(k, d);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_frame_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_SOURCE_ADDRESS: cfg_src_addr = val;
			REG_DEST_ADDRESS:   cfg_dst_addr = val;
			REG_DEST_PORT:      cfg_dst_port = val[15:0];
			REG_SOURCE_PORT:    cfg_src_port = val[15:0];
			REG_IDENT:          cfg_ident = val[15:0];
			REG_SERVICE_TYPE:   cfg_tos = val[7:0];
			REG_HOP_LIMIT:      cfg_ttl = val[7:0];
			default: begin
			end
		endcase
	endtask

	task automatic set_all_regs(input logic [31:0] src, input logic [31:0] dst,
			input logic [15:0] dport, input logic [15:0] sport, input logic [15:0] id,
			input logic [7:0] tos, input logic [7:0] ttl);
		write_reg(REG_SOURCE_ADDRESS, src);
		write_reg(REG_DEST_ADDRESS, dst);
		write_reg(REG_DEST_PORT, {16'd0, dport});
		write_reg(REG_SOURCE_PORT, {16'd0, sport});
		write_reg(REG_IDENT, {16'd0, id});
		write_reg(REG_SERVICE_TYPE, {24'd0, tos});
		write_reg(REG_HOP_LIMIT, {24'd0, ttl});
	endtask

	task automatic set_random_regs();
		set_all_regs(pick_field(32), pick_field(32), 16'(pick_field(16)),
			16'(pick_field(16)), 16'(pick_field(16)), 8'(pick_field(8)),
			8'(pick_field(8)));
	endtask

	task automatic drain_frame();
		while (frame_closed) send_word(KIND_PULL, 8'($urandom_range(0, 255)));
	endtask

	task automatic close_and_pull();
		send_word(KIND_CLOSE, 8'($urandom_range(0, 255)));
		drain_frame();
	endtask

	task automatic send_frame(input int unsigned n);
		int unsigned i;
		for (i = 0; i < n; i++) send_word(KIND_DATA, 8'($urandom_range(0, 255)));
		close_and_pull();
	endtask

	task automatic send_noise(input int unsigned n);
		int unsigned i;
		for (i = 0; i < n; i++)
			send_word(KIND_W'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
	endtask

	task automatic test_reset_values();
		send_word(KIND_PULL, 8'hFF);
		send_word(KIND_UNUSED, 8'hA5);
		close_and_pull();
		send_word(KIND_PULL, 8'h00);
	endtask

	task automatic test_register_extremes();
		wait_idle();
		set_all_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			8'hFF, 8'hFF);
		send_word(KIND_DATA, 8'hFF);
		send_word(KIND_DATA, 8'h00);
		send_word(KIND_DATA, 8'hFF);
		close_and_pull();
		wait_idle();
		set_all_regs(32'd0, 32'd0, 16'd0, 16'd0, 16'd0, 8'd0, 8'd0);
		send_word(KIND_DATA, 8'h00);
		close_and_pull();
		send_word(KIND_DATA, 8'h80);
		send_word(KIND_DATA, 8'h01);
		close_and_pull();
	endtask

	// A single payload word equal to the complemented sum of everything else makes
	// the UDP sum all ones, so the computed checksum is zero.
	task automatic test_zero_checksum();
		logic [15:0] w;
		wait_idle();
		set_random_regs();
		w = udp_sum_complement(0, 2);
		send_word(KIND_DATA, w[15:8]);
		send_word(KIND_DATA, w[7:0]);
		close_and_pull();
	endtask

	task automatic test_load_while_pending();
		send_word(KIND_DATA, 8'h5A);
		send_word(KIND_DATA, 8'hC3);
		send_word(KIND_CLOSE, 8'h00);
		send_word(KIND_DATA, 8'h77);
		send_word(KIND_CLOSE, 8'hFF);
		send_word(KIND_UNUSED, 8'h3C);
		drain_frame();
		send_word(KIND_PULL, 8'h81);
	endtask

	task automatic test_config_while_pending();
		send_word(KIND_DATA, 8'h12);
		send_word(KIND_DATA, 8'h34);
		send_word(KIND_DATA, 8'h56);
		send_word(KIND_DATA, 8'h78);
		send_word(KIND_CLOSE, 8'h00);
		wait_idle();
		set_random_regs();
		drain_frame();
	endtask

	// The full frame is closed and its headers and first payload bytes are pulled;
	// the lengths and checksums show that the surplus bytes were dropped.
	task automatic test_capacity();
		int unsigned i;
		for (i = 0; i < PAYLOAD_CAP + 5; i++)
			send_word(KIND_DATA, 8'($urandom_range(0, 255)));
		send_word(KIND_CLOSE, 8'h00);
		for (i = 0; i < HDRS_LEN + 4; i++) send_word(KIND_PULL, 8'h00);
	endtask

	task automatic test_output_backpressure();
		send_word(KIND_DATA, 8'hEE);
		send_word(KIND_CLOSE, 8'h00);
		rx_hold_req = 1'b1;
		drain_frame();
		send_frame(8);
	endtask

	task automatic test_random_frames();
		int unsigned start_words;
		int unsigned n;
		int unsigned i;
		start_words = words_used;
		while (words_used - start_words < RANDOM_WORDS) begin
			if ($urandom_range(0, 7) == 0) begin
				wait_idle();
				set_random_regs();
			end
			if ($urandom_range(0, 9) == 0) begin
				send_noise($urandom_range(1, 6));
			end
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 96) : $urandom_range(0, 48);
			for (i = 0; i < n; i++) begin
				send_word(KIND_DATA, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 29) == 0) begin
					send_noise(1);
				end
			end
			send_word(KIND_CLOSE, 8'($urandom_range(0, 255)));
			while (frame_closed) begin
				send_word(KIND_PULL, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 19) == 0) begin
					send_noise(1);
				end
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		kind <= KIND_DATA;
		payload_byte <= 8'h00;
		cfg_we <= 1'b0;
		cfg_index <= REG_SOURCE_ADDRESS;
		cfg_data <= '0;
		errors = 0;
		words_used = 0;
		burst_left = 0;
		rx_hold_req = 1'b0;
		cfg_src_addr = 32'd0;
		cfg_dst_addr = 32'd0;
		cfg_dst_port = 16'd0;
		cfg_src_port = RST_SOURCE_PORT;
		cfg_ident = 16'd0;
		cfg_tos = RST_SERVICE_TYPE;
		cfg_ttl = RST_HOP_LIMIT;
		udp_ck = 16'd0;
		hdr_ck = 16'd0;
		clear_frame_state();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_register_extremes();
		test_zero_checksum();
		test_load_while_pending();
		test_config_while_pending();
		test_output_backpressure();
		test_random_frames();
		test_capacity();

		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_frame_bytes.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && expected_frame_bytes.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
